[src/bmsq_pkg.sv]
// Package for the bucket max-score queue: widths, command and status codes,
// and the controller state type. No dependencies.
`timescale 1ns / 1ps
package bmsq_pkg;

    localparam int NODES   = 1024;
    localparam int NODE_W  = 10;
    localparam int SCORE_W = 8;
    localparam int BUCKETS = 256;
    localparam int CNT_W   = 11;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 24;
    localparam int CFG_W   = 11;

    localparam logic [CMD_W-1:0] CMD_INC     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_INC_TAKEN = 2'd1;
    localparam logic [STAT_W-1:0] ST_REM_TAKEN = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    localparam logic REG_NODE_COUNT  = 1'b0;
    localparam logic REG_SCORE_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_INC_CHK,
        S_INC_DEC,
        S_INC_ADD,
        S_POP_SCAN,
        S_REM_CHK,
        S_TK_WR,
        S_TK_DEC,
        S_FALL_RD,
        S_FALL_CK,
        S_DONE
    } t_state;

endpackage

[src/bucket_max_score_queue_top.sv]
// Bucket max-score queue over node ids, with per-node score and waiting
// memories and a bucket count memory. Depends on bmsq_pkg.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake                Payload
// s (cmd)   in   i_s_tvalid / o_s_tready  i_s_tdata: command, node_id
// m (res)   out  o_m_tvalid / i_m_tready  o_m_tdata: result_node, result_score, status
// cfg       in   i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// Increment ends at its check when taken or saturated, else it moves the node
// up one bucket; remove ends at its check when taken, after clearing the mark
// for a score of zero, after the bucket decrement below the maximum, and else
// walks the maximum down past empty buckets; pop_max scans ids in order from
// zero, then runs the same take-out walk, or ends after the last id; clear_scores
// and restart walk the score memory (restart also the marks) one entry per cycle.
// Pop_max and the maximum fall-back are bound by the single read port of each
// memory. After reset the same clearing pass runs before the first request is
// taken; configuration writes are taken at all times.
// The result sits in an output register, so a stalled result stalls only the
// next finished request, never the one being worked on.
module bucket_max_score_queue_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [2:0] command, [12:3] node_id, [15:13] zero
    input  logic [bmsq_pkg::IN_W-1:0]      i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [9:0] result_node, [17:10] result_score, [19:18] status, [23:20] zero
    output logic [bmsq_pkg::OUT_W-1:0]     o_m_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [bmsq_pkg::CFG_W-1:0]     i_cfg_data
);
    import bmsq_pkg::*;

    // Memories: scores, waiting marks and bucket counts.
    logic [SCORE_W-1:0] m_score [NODES];
    logic               m_wait  [NODES];
    logic [CNT_W-1:0]   m_bucket[BUCKETS];

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_node_count;
    logic [SCORE_W-1:0] r_score_limit;
    logic [SCORE_W-1:0] r_max;
    logic [NODE_W-1:0]  r_id;
    logic [NODE_W-1:0]  r_addr;
    logic [SCORE_W-1:0] r_score;
    logic               r_sweep_wait;   // restart pass also rewrites marks
    logic               r_sweep_emit;   // pass ends with a result

    logic [NODE_W-1:0]  r_res_node;
    logic [SCORE_W-1:0] r_res_score;
    logic [STAT_W-1:0]  r_res_status;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    logic [SCORE_W-1:0] r_sc_q;
    logic               r_wt_q;
    logic [CNT_W-1:0]   r_bk_q;

    logic [CMD_W-1:0]   in_cmd;
    logic [NODE_W-1:0]  in_id;
    logic               accept;
    logic               out_free;

    logic [NODE_W-1:0]  node_raddr;
    logic [SCORE_W-1:0] bk_raddr;
    logic               sc_we;
    logic [SCORE_W-1:0] sc_wdata;
    logic [NODE_W-1:0]  node_waddr;
    logic               wt_we;
    logic               wt_wdata;
    logic               bk_we;
    logic [SCORE_W-1:0] bk_waddr;
    logic [CNT_W-1:0]   bk_wdata;
    logic               pop_hit;

    assign in_cmd      = i_s_tdata[CMD_W-1:0];
    assign in_id       = i_s_tdata[CMD_W+NODE_W-1:CMD_W];
    assign o_s_tready  = (r_state == S_IDLE);
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_m_tready;
    assign pop_hit     = r_wt_q && (r_sc_q == r_max);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_SWEEP: begin
                if (r_addr == NODE_W'(NODES - 1)) begin
                    n_state = r_sweep_emit ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        CMD_INC:     n_state = S_INC_CHK;
                        CMD_POP:     n_state = S_POP_SCAN;
                        CMD_REMOVE:  n_state = S_REM_CHK;
                        CMD_CLEAR:   n_state = S_SWEEP;
                        CMD_RESTART: n_state = S_SWEEP;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_INC_CHK: begin
                if (!r_wt_q || r_sc_q >= r_score_limit) n_state = S_DONE;
                else n_state = S_INC_DEC;
            end
            S_INC_DEC:  n_state = S_INC_ADD;
            S_INC_ADD:  n_state = S_DONE;
            S_POP_SCAN: begin
                if (pop_hit) n_state = S_TK_WR;
                else if (r_id == NODE_W'(NODES - 1)) n_state = S_DONE;
            end
            S_REM_CHK:  n_state = r_wt_q ? S_TK_WR : S_DONE;
            S_TK_WR: begin
                if (r_score != '0) n_state = S_TK_DEC;
                else n_state = S_DONE;
            end
            S_TK_DEC:   n_state = (r_score == r_max) ? S_FALL_RD : S_DONE;
            S_FALL_RD:  n_state = (r_max == '0) ? S_DONE : S_FALL_CK;
            S_FALL_CK:  n_state = (r_bk_q == '0) ? S_FALL_RD : S_DONE;
            S_DONE:     n_state = out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Memory addresses and write strobes.
    always_comb begin
        node_raddr = r_id + NODE_W'(1);
        bk_raddr   = r_score;
        node_waddr = r_id;
        sc_we      = 1'b0;
        sc_wdata   = '0;
        wt_we      = 1'b0;
        wt_wdata   = 1'b0;
        bk_we      = 1'b0;
        bk_waddr   = r_score;
        bk_wdata   = '0;
        unique case (r_state)
            S_SWEEP: begin
                node_waddr = r_addr;
                sc_we      = 1'b1;
                wt_we      = r_sweep_wait;
                wt_wdata   = ({1'b0, r_addr} < r_node_count);
                bk_we      = (r_addr[NODE_W-1:SCORE_W] == '0);
                bk_waddr   = r_addr[SCORE_W-1:0];
            end
            S_IDLE: begin
                node_raddr = (in_cmd == CMD_POP) ? '0 : in_id;
            end
            S_INC_CHK: begin
                bk_raddr = r_sc_q;
                sc_we    = r_wt_q && (r_sc_q < r_score_limit);
                sc_wdata = r_sc_q + SCORE_W'(1);
            end
            S_INC_DEC: begin
                bk_raddr = r_score + SCORE_W'(1);
                bk_we    = (r_score != '0) && (r_bk_q != '0);
                bk_wdata = r_bk_q - CNT_W'(1);
            end
            S_INC_ADD: begin
                bk_waddr = r_score + SCORE_W'(1);
                bk_we    = 1'b1;
                bk_wdata = r_bk_q + CNT_W'(1);
            end
            S_TK_WR: begin
                wt_we = 1'b1;
            end
            S_TK_DEC: begin
                bk_we    = (r_bk_q != '0);
                bk_wdata = r_bk_q - CNT_W'(1);
            end
            S_FALL_RD: begin
                bk_raddr = r_max;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (sc_we) m_score[node_waddr] <= sc_wdata;
        if (wt_we) m_wait[node_waddr] <= wt_wdata;
        if (bk_we) m_bucket[bk_waddr] <= bk_wdata;
        r_sc_q <= m_score[node_raddr];
        r_wt_q <= m_wait[node_raddr];
        r_bk_q <= m_bucket[bk_raddr];
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_SWEEP;
            r_node_count  <= CFG_W'(NODES);
            r_score_limit <= SCORE_W'(BUCKETS - 1);
            r_max         <= '0;
            r_addr        <= '0;
            r_sweep_wait  <= 1'b1;
            r_sweep_emit  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_NODE_COUNT) r_node_count <= i_cfg_data;
                else r_score_limit <= i_cfg_data[SCORE_W-1:0];
            end
            // In S_DONE a free output register is always reloaded below.
            if (r_out_valid && i_m_tready && r_state != S_DONE) r_out_valid <= 1'b0;
            unique case (r_state)
                S_SWEEP: begin
                    r_addr <= r_addr + NODE_W'(1);
                end
                S_IDLE: begin
                    r_id         <= (in_cmd == CMD_POP) ? '0 : in_id;
                    r_res_node   <= '0;
                    r_res_score  <= '0;
                    r_res_status <= ST_OK;
                    r_addr       <= '0;
                    r_sweep_emit <= 1'b1;
                    r_sweep_wait <= (in_cmd == CMD_RESTART);
                    if (accept && (in_cmd == CMD_CLEAR || in_cmd == CMD_RESTART)) begin
                        r_max <= '0;
                    end
                end
                S_INC_CHK: begin
                    r_score <= r_sc_q;
                    if (!r_wt_q) r_res_status <= ST_INC_TAKEN;
                end
                S_INC_ADD: begin
                    if (r_score + SCORE_W'(1) > r_max) r_max <= r_score + SCORE_W'(1);
                end
                S_POP_SCAN: begin
                    if (pop_hit) begin
                        r_score     <= r_sc_q;
                        r_res_node  <= r_id;
                        r_res_score <= r_sc_q;
                    end else if (r_id == NODE_W'(NODES - 1)) begin
                        r_res_status <= ST_EMPTY;
                    end else begin
                        r_id <= r_id + NODE_W'(1);
                    end
                end
                S_REM_CHK: begin
                    r_score <= r_sc_q;
                    if (!r_wt_q) r_res_status <= ST_REM_TAKEN;
                end
                S_FALL_CK: begin
                    if (r_bk_q == '0) r_max <= r_max - SCORE_W'(1);
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {4'b0, r_res_status, r_res_score, r_res_node};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // The maximum only ever climbs one step at a time.
    a_max_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_max > $past(r_max)) |-> (r_max == $past(r_max) + SCORE_W'(1)))
        else $error("current maximum jumped by more than one");

    // A finished result waits while the output register is still held.
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_m_tready) |=> (r_state == S_DONE))
        else $error("result left while output register was busy");

    // The pop scan visits ids in order, one per cycle.
    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_SCAN && $past(r_state) == S_POP_SCAN)
        |-> (r_id == $past(r_id) + NODE_W'(1)))
        else $error("pop scan skipped an id");

    // The clearing pass stops after the last node entry.
    a_sweep_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |=> ($past(r_addr) != '1 || r_state != S_SWEEP))
        else $error("clearing pass overran");

endmodule
